// ===== rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the tabulated spectrum sampler
// Payload structs, status and mode codes, read address selects and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

    // table and field sizes
    localparam int MAX_BOUNDARIES_DEF = 64;
    localparam int EN_W     = 32;            // boundary energy, eV
    localparam int FLUX_W   = 32;            // group flux
    localparam int FRAC_W   = 32;            // uniform 0.32 fraction
    localparam int CUM_W    = 38;            // cumulative sum
    localparam int IDX_W    = 6;             // entry index field
    localparam int BC_W     = 7;             // boundary count register
    localparam int ST_W     = 2;             // status field
    localparam int Q_W      = EN_W;          // interpolation quotient
    localparam int Q_CNT_W  = $clog2(Q_W);
    localparam int PROD_W   = EN_W + CUM_W;  // 32 x 38 product
    localparam int BC_MIN   = 2;

    localparam logic [BC_W-1:0] BC_RESET = BC_W'(2);

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_BOUNDARY_COUNT = 1'b0;

    // item mode
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // result status
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_LOAD  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // table read address select
    localparam logic [2:0] ADDR_LAST = 3'd0;  // last boundary in use
    localparam logic [2:0] ADDR_ZERO = 3'd1;
    localparam logic [2:0] ADDR_NEXT = 3'd2;  // k + 1
    localparam logic [2:0] ADDR_KM1  = 3'd3;  // k - 1
    localparam logic [2:0] ADDR_K    = 3'd4;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  entry_index;
        logic [EN_W-1:0]   boundary_energy;
        logic [FLUX_W-1:0] group_flux;
        logic [FRAC_W-1:0] uniform_fraction;
    } t_in_item;

    typedef struct packed {
        logic [EN_W-1:0] sampled_energy;
        logic [ST_W-1:0] status;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic            cap_item;
        logic            load_wr;
        logic            rd_en;
        logic [2:0]      rd_sel;
        logic            lat_total;
        logic            mul_sel;     // 0: fraction x total, 1: span x offset
        logic            mul_lo;
        logic            mul_hi;
        logic            lat_target;
        logic            k_clear;
        logic            k_first;
        logic            k_step;
        logic            k_pick;
        logic            lat_lo;
        logic            prep;
        logic            div_start;
        logic            emit;
        logic [ST_W-1:0] emit_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic total_zero;
        logic scan_hit;
        logic scan_last;
        logic lastne_zero;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/tss_ram.sv =====
// ----------------------------------------------------------------------------
// tss_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/tss_div.sv =====
// ----------------------------------------------------------------------------
// tss_div: restoring divider for the bin interpolation
// Divides a 70-bit product by a 38-bit bin width, one quotient bit per
// cycle. The upper product bits are below the divisor, so 32 steps suffice.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [tss_pkg::PROD_W-1:0]  i_num,
    input  wire logic [tss_pkg::CUM_W-1:0]   i_den,
    output logic                             o_done,
    output logic [tss_pkg::Q_W-1:0]          o_quot
);

    localparam int CW = tss_pkg::CUM_W;
    localparam int QW = tss_pkg::Q_W;
    localparam logic [tss_pkg::Q_CNT_W-1:0] LAST_STEP = tss_pkg::Q_CNT_W'(QW - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [tss_pkg::Q_CNT_W-1:0] r_cnt;
    logic [CW-1:0]               r_rem;
    logic [CW-1:0]               r_den;
    logic [QW-1:0]               r_lowq;   // pending dividend bits, then quotient

    logic [CW:0]   sh;
    logic [CW:0]   diff;
    logic          ge;
    logic [CW-1:0] n_rem;

    // one restoring step
    always_comb begin
        sh    = {r_rem, r_lowq[QW-1]};
        diff  = sh - {1'b0, r_den};
        ge    = sh >= {1'b0, r_den};
        n_rem = ge ? diff[CW-1:0] : sh[CW-1:0];
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + tss_pkg::Q_CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num[tss_pkg::PROD_W-1:QW];
            r_lowq <= i_num[QW-1:0];
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_lowq <= {r_lowq[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lowq;

    // remainder stays below the divisor throughout
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder reached the divisor");

endmodule

`default_nettype wire

// ===== rtl/tss_dp.sv =====
// ----------------------------------------------------------------------------
// tss_dp: sampler datapath
// Table memories, flux accumulator, shared 32x38 multiplier, bin scan
// compare, interpolation setup, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_dp #(
    parameter int MAX_BOUNDARIES = tss_pkg::MAX_BOUNDARIES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire tss_pkg::t_in_item         i_item,
    input  wire logic [tss_pkg::BC_W-1:0]  i_boundary_count,
    input  wire tss_pkg::t_cmd             i_cmd,
    output tss_pkg::t_sts                  o_sts,
    output logic                           o_valid,
    output tss_pkg::t_out_item             o_result
);

    localparam int AW = $clog2(MAX_BOUNDARIES);
    localparam int XW = (AW + 1 > tss_pkg::BC_W) ? AW + 1 : tss_pkg::BC_W;
    localparam int EW = tss_pkg::EN_W;
    localparam int CW = tss_pkg::CUM_W;

    tss_pkg::t_in_item   r_item;
    logic [CW-1:0]       r_acc;
    logic [CW-1:0]       r_total;
    logic [2*EW-1:0]     r_plo;
    logic [tss_pkg::PROD_W-1:0] r_prod;
    logic [CW-1:0]       r_target;
    logic [AW-1:0]       r_k;
    logic [AW-1:0]       r_lastne;
    logic [CW-1:0]       r_c0;
    logic [EW-1:0]       r_e0;
    logic [CW-1:0]       r_den;
    logic [CW-1:0]       r_off;
    logic [EW-1:0]       r_mag;
    logic                r_neg;
    logic                r_valid;
    tss_pkg::t_out_item  r_result;

    logic [XW-1:0] bc_x;
    logic [XW-1:0] n_x;
    logic [AW-1:0] n_last;
    logic [XW-1:0] idx_x;
    logic          idx_ok;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [CW-1:0] acc_base;
    logic [AW-1:0] k_next;
    logic [AW-1:0] k_prev;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] en_rdata;
    logic [CW-1:0] cum_rdata;
    logic [EW-1:0] mul_a;
    logic [CW-1:0] mul_b;
    logic [2*EW-1:0] prod_lo;
    logic [CW-1:0]   prod_hi;
    logic          hit;
    logic          ne;
    logic [AW-1:0] lastne_now;
    logic [CW-1:0] den;
    logic [CW-1:0] tgt_diff;
    logic [CW-1:0] off;
    logic          hi_ge;
    logic          div_done;
    logic [tss_pkg::Q_W-1:0] quot;
    logic [EW-1:0] interp;

    // clamp boundaries in use to at least two and at most the table size
    always_comb begin
        bc_x = XW'(i_boundary_count);
        priority if (bc_x < XW'(tss_pkg::BC_MIN)) begin
            n_x = XW'(tss_pkg::BC_MIN);
        end else if (bc_x > XW'(MAX_BOUNDARIES)) begin
            n_x = XW'(MAX_BOUNDARIES);
        end else begin
            n_x = bc_x;
        end
        n_last = AW'(n_x - XW'(1));
    end

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_item <= i_item;
        end
    end

    // table load: index zero restarts the running sum
    always_comb begin
        idx_x    = XW'(r_item.entry_index);
        idx_ok   = idx_x < XW'(MAX_BOUNDARIES);
        wr_addr  = AW'(idx_x);
        wr_en    = i_cmd.load_wr && idx_ok;
        acc_base = (r_item.entry_index == '0) ? '0 : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (wr_en) begin
            r_acc <= acc_base + CW'(r_item.group_flux);
        end
    end

    // read address select
    always_comb begin
        k_next = r_k + AW'(1);
        k_prev = r_k - AW'(1);
        unique case (i_cmd.rd_sel)
            tss_pkg::ADDR_LAST: rd_addr = n_last;
            tss_pkg::ADDR_ZERO: rd_addr = '0;
            tss_pkg::ADDR_NEXT: rd_addr = k_next;
            tss_pkg::ADDR_KM1:  rd_addr = k_prev;
            tss_pkg::ADDR_K:    rd_addr = r_k;
            default:            rd_addr = '0;
        endcase
    end

    tss_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BOUNDARIES)
    ) u_en_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_item.boundary_energy),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (en_rdata)
    );

    tss_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_BOUNDARIES)
    ) u_cum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (acc_base),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (cum_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_total) begin
            r_total <= cum_rdata;
        end
    end

    // shared multiplier: low 32 bits of B first, then the top bits
    always_comb begin
        mul_a   = i_cmd.mul_sel ? r_mag : r_item.uniform_fraction;
        mul_b   = i_cmd.mul_sel ? r_off : r_total;
        prod_lo = mul_a * mul_b[EW-1:0];
        prod_hi = mul_a * mul_b[CW-1:EW];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_plo <= prod_lo;
        end
        if (i_cmd.mul_hi) begin
            r_prod <= tss_pkg::PROD_W'(r_plo) + {prod_hi, EW'(0)};
        end
        if (i_cmd.lat_target) begin
            r_target <= r_prod[tss_pkg::PROD_W-1:EW];
        end
    end

    // bin scan: compare the arriving entry with the previous one
    always_comb begin
        hit        = (r_c0 <= r_target) && (r_target < cum_rdata);
        ne         = cum_rdata > r_c0;
        lastne_now = ne ? r_k : r_lastne;
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.k_clear) begin
            r_k      <= '0;
            r_lastne <= '0;
        end else if (i_cmd.k_first) begin
            r_c0 <= cum_rdata;
            r_k  <= k_next;
        end else if (i_cmd.k_step) begin
            r_c0     <= cum_rdata;
            r_k      <= k_next;
            r_lastne <= lastne_now;
        end else if (i_cmd.k_pick) begin
            r_k <= lastne_now;
        end else if (i_cmd.lat_lo) begin
            r_c0 <= cum_rdata;
            r_e0 <= en_rdata;
        end
    end

    // interpolation setup on the upper bin edge as it arrives
    always_comb begin
        den      = cum_rdata - r_c0;
        tgt_diff = r_target - r_c0;
        priority if (r_target < r_c0) begin
            off = '0;
        end else if (tgt_diff > den) begin
            off = den;
        end else begin
            off = tgt_diff;
        end
        hi_ge = en_rdata >= r_e0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_den <= den;
            r_off <= off;
            r_mag <= hi_ge ? (en_rdata - r_e0) : (r_e0 - en_rdata);
            r_neg <= !hi_ge;
        end
    end

    tss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // result word
    assign interp = r_neg ? (r_e0 - quot) : (r_e0 + quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result.status         <= i_cmd.emit_status;
            r_result.sampled_energy <= (i_cmd.emit_status == tss_pkg::ST_OK) ? interp : '0;
        end
    end

    always_comb begin
        o_sts.total_zero  = cum_rdata == '0;
        o_sts.scan_hit    = hit;
        o_sts.scan_last   = r_k == n_last;
        o_sts.lastne_zero = lastne_now == '0;
        o_sts.div_done    = div_done;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // a load or error word never carries an energy
    a_no_energy_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.status != tss_pkg::ST_OK) |-> (r_result.sampled_energy == '0))
        else $error("non-sample result carries an energy");

endmodule

`default_nettype wire

// ===== rtl/tss_ctrl.sv =====
// ----------------------------------------------------------------------------
// tss_ctrl: sampler controller
// Sequences loads, the total check, target product, bin scan, bin fetch,
// interpolation product and division, and issues the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_mode,
    input  wire tss_pkg::t_sts  i_sts,
    output logic                o_busy,
    output tss_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_LOAD       = 4'd1;
    localparam logic [3:0] S_TOT_RD     = 4'd2;
    localparam logic [3:0] S_TOT_CHK    = 4'd3;
    localparam logic [3:0] S_TMUL_LO    = 4'd4;
    localparam logic [3:0] S_TMUL_HI    = 4'd5;
    localparam logic [3:0] S_SCAN_RD    = 4'd6;
    localparam logic [3:0] S_SCAN_FIRST = 4'd7;
    localparam logic [3:0] S_SCAN       = 4'd8;
    localparam logic [3:0] S_FET_LO     = 4'd9;
    localparam logic [3:0] S_FET_MID    = 4'd10;
    localparam logic [3:0] S_FET_HI     = 4'd11;
    localparam logic [3:0] S_IMUL_LO    = 4'd12;
    localparam logic [3:0] S_IMUL_HI    = 4'd13;
    localparam logic [3:0] S_DIV_GO     = 4'd14;
    localparam logic [3:0] S_DIV        = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap_item = 1'b1;
                    n_state = (i_mode == tss_pkg::MODE_SAMPLE) ? S_TOT_RD : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_wr     = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.emit_status = tss_pkg::ST_LOAD;
                n_state = S_IDLE;
            end
            S_TOT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = tss_pkg::ADDR_LAST;
                n_state = S_TOT_CHK;
            end
            S_TOT_CHK: begin
                if (i_sts.total_zero) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = tss_pkg::ST_EMPTY;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.lat_total = 1'b1;
                    n_state = S_TMUL_LO;
                end
            end
            S_TMUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_TMUL_HI;
            end
            S_TMUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.lat_target = 1'b1;
                o_cmd.k_clear    = 1'b1;
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_sel     = tss_pkg::ADDR_ZERO;
                n_state = S_SCAN_FIRST;
            end
            S_SCAN_FIRST: begin
                o_cmd.k_first = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = tss_pkg::ADDR_NEXT;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // stop at the first bin holding the target, else fall back
                priority if (i_sts.scan_hit) begin
                    n_state = S_FET_LO;
                end else if (i_sts.scan_last) begin
                    if (i_sts.lastne_zero) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = tss_pkg::ST_EMPTY;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.k_pick = 1'b1;
                        n_state = S_FET_LO;
                    end
                end else begin
                    o_cmd.k_step = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = tss_pkg::ADDR_NEXT;
                end
            end
            S_FET_LO: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = tss_pkg::ADDR_KM1;
                n_state = S_FET_MID;
            end
            S_FET_MID: begin
                o_cmd.lat_lo = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = tss_pkg::ADDR_K;
                n_state = S_FET_HI;
            end
            S_FET_HI: begin
                o_cmd.prep = 1'b1;
                n_state = S_IMUL_LO;
            end
            S_IMUL_LO: begin
                o_cmd.mul_sel = 1'b1;
                o_cmd.mul_lo  = 1'b1;
                n_state = S_IMUL_HI;
            end
            S_IMUL_HI: begin
                o_cmd.mul_sel = 1'b1;
                o_cmd.mul_hi  = 1'b1;
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = tss_pkg::ST_OK;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

    // an accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not start work");

    // the divider finishes only while the controller waits on it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide wait");

endmodule

`default_nettype wire

// ===== rtl/tabulated_spectrum_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// tabulated_spectrum_sampler_unit: group spectrum energy sampler
// Loads a boundary energy / cumulative flux table and draws energies by
// inverse-CDF lookup with linear interpolation inside the chosen bin.
//
//  Channel   Ports                                  Handshake
//  -------   -------------------------------------  -------------------------
//  item in   i_item (t_in_item)                     start high, busy low
//  result    o_result (t_out_item)                  o_valid, one cycle
//  config    psel penable pwrite paddr pwdata       write on access cycle,
//            prdata pready                          pready always high
//
// A load word keeps the block busy in its load state; its result follows.
// A sample word runs the total check, target product, bin scan at one
// table entry per cycle up to bin k (at most boundaries in use minus one),
// bin fetch, interpolation product and bit-serial divider; an empty
// spectrum found by the total check ends it early. Results are registered.
// Reset clears the flux sum and sets the boundary count to 2; the tables
// hold whatever was loaded. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tabulated_spectrum_sampler_unit #(
    parameter int MAX_BOUNDARIES = tss_pkg::MAX_BOUNDARIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire tss_pkg::t_in_item             i_item,
    // result channel
    output logic                               o_valid,
    output tss_pkg::t_out_item                 o_result,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tss_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tss_pkg::PDATA_W-1:0]   pwdata,
    output logic [tss_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [tss_pkg::BC_W-1:0] r_boundary_count;
    logic                     cfg_wr;
    logic                     reg_hit;
    tss_pkg::t_cmd            cmd;
    tss_pkg::t_sts            sts;

    // register decode
    assign reg_hit = paddr[tss_pkg::PADDR_W-1] == tss_pkg::REG_BOUNDARY_COUNT;
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boundary_count <= tss_pkg::BC_RESET;
        end else if (cfg_wr) begin
            r_boundary_count <= pwdata[tss_pkg::BC_W-1:0];
        end
    end

    assign prdata = reg_hit ? tss_pkg::PDATA_W'(r_boundary_count) : '0;
    assign pready = 1'b1;

    tss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_item.mode),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    tss_dp #(
        .MAX_BOUNDARIES (MAX_BOUNDARIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (i_item),
        .i_boundary_count (r_boundary_count),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .o_result         (o_result)
    );

endmodule

`default_nettype wire

// ===== tb/tabulated_spectrum_sampler_unit_test.sv =====
// ----------------------------------------------------------------------------
// tabulated_spectrum_sampler_unit_test: self-checking bench of the sampler
// Fills the boundary/cumulative tables through load words, draws energies
// with sample words and checks every result word against a cycle-free
// prediction of the table walk and bin interpolation. Runs a directed
// opener, then randomized phases over several boundary counts and sender
// idle rates, with register read-back on the configuration port.
// ----------------------------------------------------------------------------

module tabulated_spectrum_sampler_unit_test;

    localparam int TABLE_DEPTH    = tss_pkg::MAX_BOUNDARIES_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int NUM_PHASES     = 10;
    localparam int EN_W           = tss_pkg::EN_W;
    localparam int CUM_W          = tss_pkg::CUM_W;
    localparam int BC_W           = tss_pkg::BC_W;
    localparam int PROD_W         = tss_pkg::PROD_W;
    localparam int FRAC_W         = tss_pkg::FRAC_W;
    localparam int FLUX_W         = tss_pkg::FLUX_W;
    localparam int IDX_W          = tss_pkg::IDX_W;
    localparam int PADDR_W        = tss_pkg::PADDR_W;
    localparam int PDATA_W        = tss_pkg::PDATA_W;

    typedef enum int {FLUX_WIDE, FLUX_TINY, FLUX_SPARSE, FLUX_FULL} t_flux_shape;
    typedef enum int {EN_RISING, EN_FALLING, EN_SCATTER, EN_RAILS} t_energy_shape;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    logic                 busy;
    tss_pkg::t_in_item    i_item  = '0;
    logic                 o_valid;
    tss_pkg::t_out_item   o_result;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    tabulated_spectrum_sampler_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predicted table contents and configuration
    logic [EN_W-1:0]  energy_mirror [TABLE_DEPTH];
    logic [CUM_W-1:0] cum_mirror    [TABLE_DEPTH];
    logic [CUM_W-1:0] flux_sum;
    logic [BC_W-1:0]  boundary_count_shadow;

    tss_pkg::t_in_item  pending_words  [$];
    tss_pkg::t_out_item expected_words [$];

    int sender_idle_pct  = 0;
    int mismatch_count   = 0;
    int words_accepted   = 0;
    int draws_ok         = 0;
    int draws_empty      = 0;
    int loads_seen       = 0;
    int stall_cycles     = 0;

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int boundaries_in_use(input logic [BC_W-1:0] cnt);
        if (cnt < tss_pkg::BC_MIN) return tss_pkg::BC_MIN;
        if (cnt > TABLE_DEPTH) return TABLE_DEPTH;
        return int'(cnt);
    endfunction

    // predict the result of one word and advance the table state
    function automatic tss_pkg::t_out_item predict_sampler_word(input tss_pkg::t_in_item w);
        tss_pkg::t_out_item r;
        int                 n;
        int                 k;
        int                 bin;
        int                 last_rise;
        logic [CUM_W-1:0]   total;
        logic [CUM_W-1:0]   target;
        logic [CUM_W-1:0]   width;
        logic [CUM_W-1:0]   offset;
        logic [PROD_W-1:0]  prod;
        logic [EN_W-1:0]    e_lo;
        logic [EN_W-1:0]    e_hi;
        logic [EN_W-1:0]    span;
        logic [EN_W-1:0]    quot;
        r.sampled_energy = '0;
        if (w.mode == tss_pkg::MODE_LOAD) begin
            r.status = tss_pkg::ST_LOAD;
            if (w.entry_index == '0) flux_sum = '0;
            energy_mirror[w.entry_index] = w.boundary_energy;
            cum_mirror[w.entry_index]    = flux_sum;
            flux_sum = flux_sum + CUM_W'(w.group_flux);
            return r;
        end
        n     = boundaries_in_use(boundary_count_shadow);
        total = cum_mirror[n-1];
        r.status = tss_pkg::ST_EMPTY;
        if (total == '0) return r;
        prod   = PROD_W'(w.uniform_fraction) * PROD_W'(total);
        target = CUM_W'(prod >> FRAC_W);
        // first bin holding the target, and the last non-empty bin
        bin       = 0;
        last_rise = 0;
        for (k = 1; k < n; k++) begin
            if (cum_mirror[k] > cum_mirror[k-1]) last_rise = k;
            if (bin == 0 && cum_mirror[k-1] <= target && target < cum_mirror[k]) bin = k;
        end
        if (bin == 0) begin
            if (last_rise == 0) return r;
            bin = last_rise;
        end
        width = cum_mirror[bin] - cum_mirror[bin-1];
        if (target < cum_mirror[bin-1])
            offset = '0;
        else if (target - cum_mirror[bin-1] > width)
            offset = width;
        else
            offset = target - cum_mirror[bin-1];
        // interpolate on the magnitude of the energy step
        e_lo = energy_mirror[bin-1];
        e_hi = energy_mirror[bin];
        span = (e_hi >= e_lo) ? e_hi - e_lo : e_lo - e_hi;
        prod = PROD_W'(span) * PROD_W'(offset);
        quot = EN_W'(prod / PROD_W'(width));
        r.sampled_energy = (e_hi >= e_lo) ? e_lo + quot : e_lo - quot;
        r.status = tss_pkg::ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
    endtask

    // driver: hold a word until taken, then fetch the next or idle
    always @(posedge i_clk) begin
        logic               taken;
        tss_pkg::t_out_item guess;
        taken = i_rst_n && start && !busy;
        if (taken) begin
            guess = predict_sampler_word(i_item);
            expected_words.insert(expected_words.size(), guess);
            words_accepted++;
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                start  <= 1'b1;
                i_item <= pending_words.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        tss_pkg::t_out_item want;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: energy %h status %0d",
                                          o_result.sampled_energy, o_result.status));
            end else begin
                want = expected_words.pop_front();
                if (o_result.sampled_energy !== want.sampled_energy)
                    report_mismatch($sformatf("sampled_energy expected %h got %h",
                                              want.sampled_energy, o_result.sampled_energy));
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status expected %0d got %0d",
                                              want.status, o_result.status));
                case (want.status)
                    tss_pkg::ST_OK:    draws_ok++;
                    tss_pkg::ST_EMPTY: draws_empty++;
                    default:           loads_seen++;
                endcase
            end
        end
    end

    // watchdog: abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
                $display("tabulated_spectrum_sampler_unit_test: done, errors");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic tss_pkg::t_in_item make_word(input logic mode,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [EN_W-1:0] e,
                                                    input logic [FLUX_W-1:0] f,
                                                    input logic [FRAC_W-1:0] u);
        tss_pkg::t_in_item w;
        w.mode             = mode;
        w.entry_index      = idx;
        w.boundary_energy  = e;
        w.group_flux       = f;
        w.uniform_fraction = u;
        return w;
    endfunction

    task automatic queue_load(input int idx, input logic [EN_W-1:0] e,
                              input logic [FLUX_W-1:0] f);
        pending_words.insert(pending_words.size(),
                             make_word(tss_pkg::MODE_LOAD, IDX_W'(idx), e, f, $urandom()));
    endtask

    task automatic queue_draw(input logic [FRAC_W-1:0] u);
        pending_words.insert(pending_words.size(),
                             make_word(tss_pkg::MODE_SAMPLE, IDX_W'($urandom()), $urandom(),
                                       $urandom(), u));
    endtask

    function automatic logic [FRAC_W-1:0] pick_fraction();
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return $urandom();
    endfunction

    function automatic logic [FLUX_W-1:0] pick_flux(input t_flux_shape shape);
        case (shape)
            FLUX_TINY:   return FLUX_W'($urandom_range(15));
            FLUX_SPARSE: return ($urandom_range(9) == 0) ? FLUX_W'($urandom()) : '0;
            FLUX_FULL:   return '1;
            default:     return $urandom();
        endcase
    endfunction

    // load a whole table, index 0 upward, with shaped content
    task automatic queue_table(input int len, input t_flux_shape fshape,
                               input t_energy_shape eshape);
        logic [EN_W-1:0] e;
        int              i;
        e = (eshape == EN_FALLING) ? '1 : EN_W'($urandom_range(1000));
        for (i = 0; i < len; i++) begin
            case (eshape)
                EN_RISING:  if (i != 0) e = e + EN_W'($urandom_range(1 << 25));
                EN_FALLING: if (i != 0) e = e - EN_W'($urandom_range(1 << 25));
                EN_SCATTER: e = $urandom();
                default:    e = i[0] ? '1 : '0;
            endcase
            queue_load(i, e, pick_flux(fshape));
        end
    endtask

    // optional write of the boundary count, then read it back
    task automatic access_boundary_count(input bit do_write, input logic [BC_W-1:0] value);
        if (do_write) begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {tss_pkg::REG_BOUNDARY_COUNT, 2'b00};
            pwdata  <= PDATA_W'(value);
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            boundary_count_shadow = value;
            penable <= 1'b0;
            psel    <= 1'b0;
        end
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {tss_pkg::REG_BOUNDARY_COUNT, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        if (prdata !== PDATA_W'(boundary_count_shadow))
            report_mismatch($sformatf("boundary_count read expected %0d got %0d",
                                      boundary_count_shadow, prdata));
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_words.size() != 0 || start)
            @(posedge i_clk);
    endtask

    // stimulus and phase control
    initial begin
        logic [BC_W-1:0] phase_counts [NUM_PHASES];
        int              idle_plan [3];
        int              ph;
        int              n_eff;
        int              tbl_len;
        int              budget;
        int              r;
        int              i;

        phase_counts = '{7'd127, 7'd0, 7'd64, 7'd1, 7'd5, 7'd33, 7'd2, 7'd0, 7'd100, 7'd17};
        phase_counts[7] = BC_W'($urandom_range(3, 63));
        idle_plan = '{0, 48, 15};
        flux_sum = '0;
        boundary_count_shadow = tss_pkg::BC_RESET;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            energy_mirror[i] = '0;
            cum_mirror[i]    = '0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        access_boundary_count(1'b0, tss_pkg::BC_RESET);

        // directed: empty spectrum, rail energies and fractions, falling bin
        queue_load(0, '0, '0);
        queue_load(1, '1, '1);
        queue_draw('1);
        queue_load(0, '0, '1);
        queue_load(1, '1, '0);
        queue_draw('0);
        queue_draw('1);
        queue_draw(32'h8000_0000);
        queue_draw(32'h0000_0001);
        queue_load(0, '1, 32'd1);
        queue_load(1, '0, '1);
        queue_draw('1);
        queue_draw('0);
        // top entry index and a flat bin
        queue_load(63, $urandom(), $urandom());
        queue_load(42, $urandom(), $urandom());
        queue_load(0, 32'd10, 32'd3);
        queue_load(1, 32'd10, '0);
        queue_draw(32'h7FFF_FFFF);
        wait_drained();

        // random phases over boundary counts and idle rates
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            access_boundary_count(1'b1, phase_counts[ph]);
            sender_idle_pct = idle_plan[ph % 3];
            n_eff   = boundaries_in_use(phase_counts[ph]);
            tbl_len = n_eff + $urandom_range(0, 3);
            if (tbl_len > TABLE_DEPTH) tbl_len = TABLE_DEPTH;
            if (n_eff == TABLE_DEPTH)
                queue_table(tbl_len, FLUX_FULL, t_energy_shape'($urandom_range(3)));
            else
                queue_table(tbl_len, t_flux_shape'($urandom_range(3)),
                            t_energy_shape'($urandom_range(3)));
            budget = 50 + tbl_len;
            while (pending_words.size() < budget) begin
                r = $urandom_range(99);
                if (r < 74) begin
                    queue_draw(pick_fraction());
                end else if (r < 90) begin
                    // stray load: breaks the ordering of the cumulative sums
                    queue_load($urandom_range(TABLE_DEPTH - 1), $urandom(),
                               pick_flux(t_flux_shape'($urandom_range(3))));
                end else if (n_eff <= 16 || r < 92) begin
                    queue_table(n_eff, t_flux_shape'($urandom_range(3)),
                                t_energy_shape'($urandom_range(3)));
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_words.size()));

        $display("covered %0d words: %0d loads, %0d interpolated draws, %0d empty spectra",
                 words_accepted, loads_seen, draws_ok, draws_empty);
        $display("over %0d boundary-count settings, sender idle 0/48/15 percent, %0d mismatches",
                 NUM_PHASES + 1, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tabulated_spectrum_sampler_unit_test: done, clean");
        end else begin
            $display("tabulated_spectrum_sampler_unit_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tss_pkg.sv
rtl/tss_ram.sv
rtl/tss_div.sv
rtl/tss_dp.sv
rtl/tss_ctrl.sv
rtl/tabulated_spectrum_sampler_unit.sv
tb/tabulated_spectrum_sampler_unit_test.sv
